### hdl/wtsp_pkg.sv
// Shared types and constants for the world-to-screen projection core.
// No dependencies.
`default_nettype none
package wtsp_pkg;
    localparam int unsigned COORD_W = 32;   // Q16.16 coordinate width
    localparam int unsigned FRAC_W  = 16;   // fraction bits
    localparam int unsigned SUM_W   = 50;   // column accumulator width
    localparam int unsigned COEF_N  = 8;    // number of coefficient registers
    localparam int unsigned ADDR_W  = 6;    // APB byte address width
    localparam int unsigned DATA_W  = 64;   // APB data width

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic signed [SUM_W-1:0]   t_sum;

    // One beat moving through the divider pipeline
    typedef struct packed {
        logic                 vld;
        logic [SUM_W:0]       rem_x;
        logic [SUM_W:0]       rem_y;
        logic [COORD_W-1:0]   low_x;
        logic [COORD_W-1:0]   low_y;
        logic [COORD_W-1:0]   q_x;
        logic [COORD_W-1:0]   q_y;
        logic [SUM_W-1:0]     den;
        logic                 neg_x;
        logic                 neg_y;
        logic                 ovf_x;
        logic                 ovf_y;
        logic                 fault;
    } t_div;
endpackage
`default_nettype wire

### hdl/wtsp_if.sv
// Valid/ready channel interfaces for points in and screen coordinates out.
// Depends on wtsp_pkg.
`default_nettype none
interface wtsp_point_if import wtsp_pkg::*; ();
    logic   valid;
    logic   ready;
    t_coord point_x;
    t_coord point_y;
    t_coord point_z;
    modport source (output valid, output point_x, output point_y, output point_z,
                    input ready);
    modport sink   (input valid, input point_x, input point_y, input point_z,
                    output ready);
endinterface

interface wtsp_screen_if import wtsp_pkg::*; ();
    logic   valid;
    logic   ready;
    t_coord screen_x;
    t_coord screen_y;
    logic   divide_fault;
    modport source (output valid, output screen_x, output screen_y,
                    output divide_fault, input ready);
    modport sink   (input valid, input screen_x, input screen_y,
                    input divide_fault, output ready);
endinterface
`default_nettype wire

### hdl/world_to_screen_projection_core.sv
// Takes one Q16.16 point per cycle, multiplies [x y z 1] by a 4x4 Q16.16 matrix
// held in eight 64-bit APB registers, and returns x/w and y/w saturated to Q16.16.
// A point is accepted every cycle the output side is not stalled; the pipeline
// is multiply, column sum, magnitude/range check, one quotient bit per
// stage of a 32-stage restoring divider for each of x and y, and the output
// register. A zero w (after truncation to Q16.16) sets divide_fault and zero
// coordinates. Reset loads the identity matrix.
// Depends on wtsp_pkg and the interfaces in wtsp_if.sv.
`default_nettype none
module world_to_screen_projection_core import wtsp_pkg::*; (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    wtsp_point_if.sink          i_pt,
    wtsp_screen_if.source       o_scr,
    input  wire                 psel,
    input  wire                 penable,
    input  wire                 pwrite,
    input  wire  [ADDR_W-1:0]   paddr,
    input  wire  [DATA_W-1:0]   pwdata,
    output logic [DATA_W-1:0]   prdata,
    output logic                pready
);
    localparam int unsigned QB = COORD_W;  // quotient bits, one per stage

    logic [DATA_W-1:0] r_coef [COEF_N];
    logic              en;

    // ---------------- configuration ----------------
    assign pready = 1'b1;
    assign prdata = r_coef[paddr[ADDR_W-1:3]];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef[0] <= 64'h0000_0000_0001_0000;
            r_coef[1] <= '0;
            r_coef[2] <= 64'h0001_0000_0000_0000;
            r_coef[3] <= '0;
            r_coef[4] <= '0;
            r_coef[5] <= 64'h0000_0000_0001_0000;
            r_coef[6] <= '0;
            r_coef[7] <= 64'h0001_0000_0000_0000;
        end else if (psel && penable && pwrite) begin
            r_coef[paddr[ADDR_W-1:3]] <= pwdata;
        end
    end

    function automatic t_coord coef(input logic [DATA_W-1:0] r, input logic hi);
        coef = hi ? t_coord'(r[63:32]) : t_coord'(r[31:0]);
    endfunction

    assign en       = !o_scr.valid || o_scr.ready;
    assign i_pt.ready = en;

    // ---------------- stage 1: products ----------------
    // r_prod[col][row], only columns 0, 1 and 3 are needed
    logic signed [2*COORD_W-1:0] r_prod [3][3];
    logic                        r_s1_vld;
    t_coord                      v [3];
    logic [1:0]                  col_of [3];

    assign v[0] = i_pt.point_x;
    assign v[1] = i_pt.point_y;
    assign v[2] = i_pt.point_z;
    assign col_of[0] = 2'd0;
    assign col_of[1] = 2'd1;
    assign col_of[2] = 2'd3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (en) begin
            r_s1_vld <= i_pt.valid;
        end
    end

    for (genvar c = 0; c < 3; c++) begin : g_col
        for (genvar r = 0; r < 3; r++) begin : g_row
            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_prod[c][r] <= v[r] *
                        coef(r_coef[{2'(r), col_of[c][1]}], col_of[c][0]);
                end
            end
        end
    end

    // ---------------- stage 2: column sums ----------------
    t_sum r_t [3];
    logic r_s2_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else if (en) begin
            r_s2_vld <= r_s1_vld;
        end
    end

    for (genvar c = 0; c < 3; c++) begin : g_sum
        always_ff @(posedge i_clk) begin
            if (en) begin
                // arithmetic shift is floor division by 2^16
                r_t[c] <= t_sum'(r_prod[c][0] >>> FRAC_W)
                        + t_sum'(r_prod[c][1] >>> FRAC_W)
                        + t_sum'(r_prod[c][2] >>> FRAC_W)
                        + t_sum'(coef(r_coef[{2'd3, col_of[c][1]}], col_of[c][0]));
            end
        end
    end

    // ---------------- stage 3: magnitudes and range check ----------------
    t_div                   s [QB+1];
    t_div                   n_s0;
    logic [SUM_W-1:0]       mx, my, mw;

    assign mx = r_t[0][SUM_W-1] ? SUM_W'(-r_t[0]) : SUM_W'(r_t[0]);
    assign my = r_t[1][SUM_W-1] ? SUM_W'(-r_t[1]) : SUM_W'(r_t[1]);
    assign mw = r_t[2][SUM_W-1] ? SUM_W'(-r_t[2]) : SUM_W'(r_t[2]);

    always_comb begin
        n_s0       = '0;
        n_s0.vld   = r_s2_vld;
        // quotient >= 2^32 when |t| >= |w| << 16
        n_s0.ovf_x = {16'b0, mx} >= {mw, 16'b0};
        n_s0.ovf_y = {16'b0, my} >= {mw, 16'b0};
        n_s0.rem_x = (SUM_W+1)'(mx[SUM_W-1:FRAC_W]);
        n_s0.rem_y = (SUM_W+1)'(my[SUM_W-1:FRAC_W]);
        n_s0.low_x = {mx[FRAC_W-1:0], 16'b0};
        n_s0.low_y = {my[FRAC_W-1:0], 16'b0};
        n_s0.den   = mw;
        n_s0.neg_x = r_t[0][SUM_W-1] != r_t[2][SUM_W-1];
        n_s0.neg_y = r_t[1][SUM_W-1] != r_t[2][SUM_W-1];
        n_s0.fault = (r_t[2] == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            s[0].vld <= 1'b0;
        end else if (en) begin
            s[0] <= n_s0;
        end
    end

    // ---------------- restoring divider, one bit per stage ----------------
    for (genvar i = 0; i < QB; i++) begin : g_div
        t_div             n_d;
        logic [SUM_W:0]   tx, ty;
        always_comb begin
            n_d   = s[i];
            tx    = {s[i].rem_x[SUM_W-1:0], s[i].low_x[QB-1]};
            ty    = {s[i].rem_y[SUM_W-1:0], s[i].low_y[QB-1]};
            n_d.low_x = {s[i].low_x[QB-2:0], 1'b0};
            n_d.low_y = {s[i].low_y[QB-2:0], 1'b0};
            if (tx >= {1'b0, s[i].den}) begin
                n_d.rem_x = tx - {1'b0, s[i].den};
                n_d.q_x   = {s[i].q_x[QB-2:0], 1'b1};
            end else begin
                n_d.rem_x = tx;
                n_d.q_x   = {s[i].q_x[QB-2:0], 1'b0};
            end
            if (ty >= {1'b0, s[i].den}) begin
                n_d.rem_y = ty - {1'b0, s[i].den};
                n_d.q_y   = {s[i].q_y[QB-2:0], 1'b1};
            end else begin
                n_d.rem_y = ty;
                n_d.q_y   = {s[i].q_y[QB-2:0], 1'b0};
            end
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                s[i+1].vld <= 1'b0;
            end else if (en) begin
                s[i+1] <= n_d;
            end
        end
    end

    // ---------------- output: sign and saturation ----------------
    function automatic t_coord sat(input logic [QB-1:0] q, input logic ovf,
                                   input logic neg);
        logic big;
        big = ovf || q[QB-1];
        if (neg) begin
            sat = big ? t_coord'(32'h8000_0000) : t_coord'(-q);
        end else begin
            sat = big ? t_coord'(32'h7FFF_FFFF) : t_coord'(q);
        end
    endfunction

    t_div d;
    assign d = s[QB];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_scr.valid <= 1'b0;
        end else if (en) begin
            o_scr.valid <= d.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            o_scr.divide_fault <= d.fault;
            o_scr.screen_x     <= d.fault ? '0 : sat(d.q_x, d.ovf_x, d.neg_x);
            o_scr.screen_y     <= d.fault ? '0 : sat(d.q_y, d.ovf_y, d.neg_y);
        end
    end
endmodule
`default_nettype wire
